// ===== hdl/ics_pkg.sv =====
// ---------------------------------------------------------------------------
// ics_pkg: shared types and constants for the Internet checksum engine
// Item layout, command/mode codes and ones'-complement helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package ics_pkg;

  localparam int unsigned WordW = 16;

  // command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  // start modes
  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_TCP   = 2'd1;
  localparam logic [1:0] MODE_UDP   = 2'd2;

  // byte counts with special meaning
  localparam logic [1:0] BC_NONE = 2'd0;
  localparam logic [1:0] BC_HIGH = 2'd1;

  localparam logic [WordW-1:0] PROTO_TCP = 16'd6;
  localparam logic [WordW-1:0] PROTO_UDP = 16'd17;
  localparam logic [WordW-1:0] ALL_ONES  = 16'hffff;

  typedef struct packed {
    logic        command;
    logic [1:0]  mode;
    logic [31:0] ip_src;
    logic [31:0] ip_dst;
    logic [15:0] ip_total_length;
    logic [3:0]  ip_header_words;
    logic [15:0] udp_length;
    logic [15:0] data_word;
    logic [1:0]  byte_count;
    logic        last_word;
  } ics_item_t;

  // operand handed from the decode logic to the accumulator
  typedef struct packed {
    logic             load;   // start: replace the sum with value
    logic             emit;   // last data word: send checksum, clear sum
    logic [WordW-1:0] value;
  } ics_op_t;

  // 16-bit add with end-around carry
  function automatic logic [WordW-1:0] oc_add(input logic [WordW-1:0] a,
                                              input logic [WordW-1:0] b);
    logic [WordW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WordW-1:0] + {{(WordW-1){1'b0}}, s[WordW]};
  endfunction

  // fold a 19-bit plain sum back into 16 bits with end-around carry
  function automatic logic [WordW-1:0] oc_fold19(input logic [18:0] v);
    logic [WordW:0] t;
    t = {1'b0, v[15:0]} + {14'b0, v[18:16]};
    return t[WordW-1:0] + {{(WordW-1){1'b0}}, t[WordW]};
  endfunction

endpackage

`default_nettype wire

// ===== hdl/ics_operand.sv =====
// ---------------------------------------------------------------------------
// ics_operand: item decode
// Turns one registered item into a load/add operand; builds the
// pseudo-header seed for start items.
// ---------------------------------------------------------------------------
`default_nettype none

module ics_operand
  import ics_pkg::*;
(
  input  ics_item_t item,
  output ics_op_t   op
);

  logic [15:0] proto;
  logic [15:0] seg_len;
  logic [18:0] seed_raw;
  logic [15:0] seed;
  logic [15:0] data_val;
  logic        pseudo;

  assign pseudo = (item.mode == MODE_TCP) || (item.mode == MODE_UDP);

  // TCP length = total length - 4*IHL, wrapped to 16 bits
  always_comb begin
    if (item.mode == MODE_TCP) begin
      proto   = PROTO_TCP;
      seg_len = item.ip_total_length - {10'b0, item.ip_header_words, 2'b00};
    end else begin
      proto   = PROTO_UDP;
      seg_len = item.udp_length;
    end
  end

  // six-term plain sum, then two end-around folds
  assign seed_raw = {3'b0, item.ip_src[31:16]} + {3'b0, item.ip_src[15:0]}
                  + {3'b0, item.ip_dst[31:16]} + {3'b0, item.ip_dst[15:0]}
                  + {3'b0, proto} + {3'b0, seg_len};
  assign seed = pseudo ? oc_fold19(seed_raw) : 16'h0000;

  always_comb begin
    case (item.byte_count)
      BC_NONE: data_val = 16'h0000;
      BC_HIGH: data_val = {item.data_word[15:8], 8'h00};
      default: data_val = item.data_word;
    endcase
  end

  assign op.load  = (item.command == CMD_START);
  assign op.emit  = (item.command == CMD_DATA) && item.last_word;
  assign op.value = op.load ? seed : data_val;

endmodule

`default_nettype wire

// ===== hdl/ics_accum.sv =====
// ---------------------------------------------------------------------------
// ics_accum: running sum and result register
// Adds operands with end-around carry; holds the checksum until taken.
// ---------------------------------------------------------------------------
`default_nettype none

module ics_accum
  import ics_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        op_valid,
  output logic        op_ready,
  input  ics_op_t     op,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [15:0] checksum
);

  logic [15:0] running_sum;
  logic [15:0] sum_next;
  logic        slot_free;
  logic        adv;

  assign slot_free = !result_valid || result_ready;
  assign op_ready  = !op.emit || slot_free;
  assign adv       = op_valid && op_ready;
  assign sum_next  = oc_add(running_sum, op.value);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum  <= 16'h0000;
      result_valid <= 1'b0;
    end else begin
      // a new checksum wins over the drain of the old one
      if (adv && op.emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (adv) begin
        if (op.load) begin
          running_sum <= op.value;
        end else if (op.emit) begin
          running_sum <= 16'h0000;
          checksum    <= ~sum_next;
        end else begin
          running_sum <= sum_next;
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_seed_loaded: assert property (@(posedge clk) disable iff (rst)
    adv && op.load |=> running_sum == $past(op.value))
    else $error("start transfer did not seed the running sum");

  a_sum_cleared: assert property (@(posedge clk) disable iff (rst)
    adv && op.emit |=> running_sum == 16'h0000 && result_valid)
    else $error("last word did not clear the sum and post a result");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !op_ready |-> op.emit && result_valid && !result_ready)
    else $error("operand stalled without a pending result");
`endif

endmodule

`default_nettype wire

// ===== hdl/internet_checksum_pseudo_header_top.sv =====
// ---------------------------------------------------------------------------
// internet_checksum_pseudo_header_top: streaming Internet checksum
// Ones'-complement checksum with TCP/UDP pseudo-header seeding.
// ---------------------------------------------------------------------------
// Takes one item per clock unless a last word meets an unread checksum. A start
// item (command 0) seeds the running sum: zero for plain/IPv4-header mode
// (and the unused mode 3), or the IPv4 pseudo-header for TCP (protocol 6,
// length = ip_total_length - 4*ip_header_words) or UDP (protocol 17,
// length = udp_length). Data items (command 1) add data_word with
// end-around carry; byte_count 1 adds only the high byte, 0 adds nothing.
// The data item with last_word set produces one checksum transfer, the
// inverted sum, which passes through the input register and then the
// result register, and clears the sum. Data sent without a start simply
// accumulates onto the current sum. The result register is decoupled from
// the input: new items are taken while a checksum waits, and only a last
// word that meets an unread checksum stalls the input.
// ---------------------------------------------------------------------------
`default_nettype none

module internet_checksum_pseudo_header_top
  import ics_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // item channel
  input  logic        item_valid,
  output logic        item_ready,
  input  logic        command,
  input  logic [1:0]  mode,
  input  logic [31:0] ip_src,
  input  logic [31:0] ip_dst,
  input  logic [15:0] ip_total_length,
  input  logic [3:0]  ip_header_words,
  input  logic [15:0] udp_length,
  input  logic [15:0] data_word,
  input  logic [1:0]  byte_count,
  input  logic        last_word,
  // result channel
  output logic        result_valid,
  input  logic        result_ready,
  output logic [15:0] checksum
);

  // input register
  ics_item_t stg_item;
  logic      stg_valid;
  logic      stg_ready;
  ics_op_t   stg_op;

  // the input register refills whenever it is empty or drains this cycle
  assign item_ready = !stg_valid || stg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (item_ready) begin
      stg_valid <= item_valid;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      stg_item.command         <= command;
      stg_item.mode            <= mode;
      stg_item.ip_src          <= ip_src;
      stg_item.ip_dst          <= ip_dst;
      stg_item.ip_total_length <= ip_total_length;
      stg_item.ip_header_words <= ip_header_words;
      stg_item.udp_length      <= udp_length;
      stg_item.data_word       <= data_word;
      stg_item.byte_count      <= byte_count;
      stg_item.last_word       <= last_word;
    end
  end

  // decode: seed or data operand
  ics_operand u_operand (
    .item (stg_item),
    .op   (stg_op)
  );

  // running sum and result register
  ics_accum u_accum (
    .clk          (clk),
    .rst          (rst),
    .op_valid     (stg_valid),
    .op_ready     (stg_ready),
    .op           (stg_op),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .checksum     (checksum)
  );

endmodule

`default_nettype wire
